FILE: rtl/bp_pkg.sv
// shared types and constants of the reference-counted buffer pool
// no dependencies; used by every module of the pool except bp_ram
`default_nettype none

package bp_pkg;

  localparam int BP_ENTRIES  = 256;
  localparam int BP_REF_BITS = 8;

  localparam int OP_W     = 2;
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;
  localparam int FREE_W   = 9;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADDREF  = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_EXHAUSTED   = 3'd1,
    ST_BAD_INDEX   = 3'd2,
    ST_DOUBLE_FREE = 3'd3,
    ST_REF_ERROR   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    K_ALLOC,
    K_ADDREF,
    K_RELEASE,
    K_BAD
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  idx;
  } bp_item_t;

endpackage

`default_nettype wire

FILE: rtl/bp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/bp_front.sv
// front end: takes request beats, classifies them and holds them in a short queue
// depends on bp_pkg
`default_nettype none

module bp_front #(
  parameter int ENTRIES = bp_pkg::BP_ENTRIES
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire logic [bp_pkg::OP_W-1:0]    operation,
  input  wire logic [bp_pkg::IDX_W-1:0]   buffer_index,
  output logic                            item_valid,
  output bp_pkg::bp_item_t                item,
  input  wire logic                       item_pop
);

  bp_pkg::bp_item_t q [2];
  logic             wr_sel;
  logic             rd_sel;
  logic [1:0]       fill;
  logic             push;
  bp_pkg::bp_item_t cls;

  always_comb begin
    cls.idx = buffer_index;
    case (operation)
      bp_pkg::OP_ALLOC:  cls.kind = bp_pkg::K_ALLOC;
      bp_pkg::OP_ADDREF: cls.kind = bp_pkg::K_ADDREF;
      default:           cls.kind = bp_pkg::K_RELEASE;
    endcase
    if (operation != bp_pkg::OP_ALLOC && 32'(buffer_index) >= 32'(ENTRIES)) begin
      cls.kind = bp_pkg::K_BAD;
    end
  end

  assign req_stall  = fill[1];
  assign push       = req_valid && !req_stall;
  assign item_valid = fill != 2'd0;
  assign item       = q[rd_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_sel <= !wr_sel;
      end
      if (item_pop) begin
        rd_sel <= !rd_sel;
      end
      if (push && !item_pop) begin
        fill <= fill + 2'd1;
      end else if (!push && item_pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_sel] <= cls;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bp_back.sv
// back end: reads count and ring memories, applies the operation, drives the response beat
// depends on bp_pkg and bp_ram
`default_nettype none

module bp_back #(
  parameter int ENTRIES  = bp_pkg::BP_ENTRIES,
  parameter int REF_BITS = bp_pkg::BP_REF_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  input  wire bp_pkg::bp_item_t             item,
  output logic                              item_pop,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output logic [bp_pkg::STATUS_W-1:0]       status,
  output logic [bp_pkg::IDX_W-1:0]          granted_index,
  output logic [bp_pkg::COUNT_W-1:0]        count_after,
  output logic                              returned_to_pool,
  output logic [bp_pkg::FREE_W-1:0]         free_entries
);

  localparam int AW    = $clog2(ENTRIES);
  localparam int PTR_W = $clog2(2 * ENTRIES);
  localparam int FC_W  = $clog2(ENTRIES + 1);

  localparam logic [PTR_W-1:0]    ENT_P   = PTR_W'(ENTRIES);
  localparam logic [PTR_W-1:0]    SPAN_P  = PTR_W'(2 * ENTRIES);
  localparam logic [PTR_W-1:0]    LAST_P  = PTR_W'(2 * ENTRIES - 1);
  localparam logic [FC_W-1:0]     ENT_F   = FC_W'(ENTRIES);
  localparam logic [AW-1:0]       LAST_A  = AW'(ENTRIES - 1);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;
  localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [AW-1:0]        clr_addr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr_next;
  logic [PTR_W-1:0]     wr_ptr_next;
  logic [FC_W-1:0]      fill;
  bp_pkg::bp_item_t     cur;
  logic                 ring_hit;
  logic [AW-1:0]        slot_q;
  logic [AW-1:0]        rd_slot;
  logic [AW-1:0]        wr_slot;
  logic [AW-1:0]        ring_val;
  logic                 issue;
  logic                 exec;

  logic                 cnt_we;
  logic [AW-1:0]        cnt_waddr;
  logic [REF_BITS-1:0]  cnt_wdata;
  logic [REF_BITS-1:0]  cnt_rdata;
  logic                 ring_we;
  logic [AW-1:0]        ring_rdata;

  bp_pkg::status_t      r_status;
  logic [AW-1:0]        r_granted;
  logic [REF_BITS-1:0]  r_count;
  logic                 r_returned;
  logic [PTR_W-1:0]     free_next;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_P) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [AW-1:0] slot_of(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    s = (p >= ENT_P) ? p - ENT_P : p;
    return s[AW-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] free_of(input logic [PTR_W-1:0] w,
                                                input logic [PTR_W-1:0] r);
    logic [PTR_W-1:0] d;
    d = w - r;
    if (w < r) begin
      d = d + SPAN_P;
    end
    return d;
  endfunction

  assign rd_slot  = slot_of(rd_ptr);
  assign wr_slot  = slot_of(wr_ptr);
  assign issue    = (state == S_IDLE) && item_valid && (!rsp_valid || !rsp_stall);
  assign exec     = state == S_EXEC;
  assign item_pop = issue;
  assign ring_val = ring_hit ? ring_rdata : slot_q;

  bp_ram #(
    .WIDTH (REF_BITS),
    .DEPTH (ENTRIES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (AW'(item.idx)),
    .rdata (cnt_rdata)
  );

  bp_ram #(
    .WIDTH (AW),
    .DEPTH (ENTRIES)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wr_slot),
    .wdata (AW'(cur.idx)),
    .raddr (rd_slot),
    .rdata (ring_rdata)
  );

  always_comb begin
    state_next  = state;
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    cnt_we      = 1'b0;
    cnt_waddr   = clr_addr;
    cnt_wdata   = '0;
    ring_we     = 1'b0;
    r_status    = bp_pkg::ST_OK;
    r_granted   = AW'(cur.idx);
    r_count     = '0;
    r_returned  = 1'b0;

    case (state)
      S_CLEAR: begin
        cnt_we = 1'b1;
        if (clr_addr == LAST_A) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (issue) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        case (cur.kind)
          bp_pkg::K_ALLOC: begin
            if (free_of(wr_ptr, rd_ptr) == '0) begin
              r_status  = bp_pkg::ST_EXHAUSTED;
              r_granted = '0;
            end else begin
              r_granted   = ring_val;
              r_count     = REF_ONE;
              rd_ptr_next = ptr_inc(rd_ptr);
              cnt_we      = 1'b1;
              cnt_waddr   = ring_val;
              cnt_wdata   = REF_ONE;
            end
          end
          bp_pkg::K_ADDREF: begin
            r_count = cnt_rdata;
            if (cnt_rdata == '0 || cnt_rdata == REF_MAX) begin
              r_status = bp_pkg::ST_REF_ERROR;
            end else begin
              r_count   = cnt_rdata + REF_ONE;
              cnt_we    = 1'b1;
              cnt_waddr = AW'(cur.idx);
              cnt_wdata = cnt_rdata + REF_ONE;
            end
          end
          bp_pkg::K_RELEASE: begin
            r_count = cnt_rdata;
            if (cnt_rdata == '0) begin
              r_status = bp_pkg::ST_DOUBLE_FREE;
            end else begin
              r_count   = cnt_rdata - REF_ONE;
              cnt_we    = 1'b1;
              cnt_waddr = AW'(cur.idx);
              cnt_wdata = cnt_rdata - REF_ONE;
              if (cnt_rdata == REF_ONE) begin
                ring_we     = 1'b1;
                wr_ptr_next = ptr_inc(wr_ptr);
                r_returned  = 1'b1;
              end
            end
          end
          default: begin
            r_status = bp_pkg::ST_BAD_INDEX;
          end
        endcase
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign free_next = free_of(wr_ptr_next, rd_ptr_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rd_ptr    <= '0;
      wr_ptr    <= ENT_P;
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (ring_we && fill != ENT_F) begin
        fill <= fill + FC_W'(1);
      end
      if (exec) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cur      <= item;
      ring_hit <= FC_W'(rd_slot) < fill;
      slot_q   <= rd_slot;
    end
    if (exec) begin
      status           <= r_status;
      granted_index    <= bp_pkg::IDX_W'(r_granted);
      count_after      <= bp_pkg::COUNT_W'(r_count);
      returned_to_pool <= r_returned;
      free_entries     <= bp_pkg::FREE_W'(free_next);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/refcounted_buffer_pool.sv
// a request beat is queued in the front end, issued in S_IDLE, carried out in
// S_EXEC and registered as the response beat; the back end takes no new beat
// until S_EXEC is done, as the count ram is read then written; the front queue
// holds 2 beats, so requests are taken while the back end works; reset:
// synchronous; a clearing pass zeroes the count ram, during which up to 2 request
// beats are queued but not carried out; depends on bp_pkg, bp_front, bp_back
`default_nettype none

module refcounted_buffer_pool #(
  parameter int ENTRIES  = bp_pkg::BP_ENTRIES,
  parameter int REF_BITS = bp_pkg::BP_REF_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire logic [bp_pkg::OP_W-1:0]    operation,
  input  wire logic [bp_pkg::IDX_W-1:0]   buffer_index,
  output logic                            rsp_valid,
  input  wire logic                       rsp_stall,
  output logic [bp_pkg::STATUS_W-1:0]     status,
  output logic [bp_pkg::IDX_W-1:0]        granted_index,
  output logic [bp_pkg::COUNT_W-1:0]      count_after,
  output logic                            returned_to_pool,
  output logic [bp_pkg::FREE_W-1:0]       free_entries
);

  logic             item_valid;
  logic             item_pop;
  bp_pkg::bp_item_t item;

  bp_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .operation    (operation),
    .buffer_index (buffer_index),
    .item_valid   (item_valid),
    .item         (item),
    .item_pop     (item_pop)
  );

  bp_back #(
    .ENTRIES  (ENTRIES),
    .REF_BITS (REF_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item             (item),
    .item_pop         (item_pop),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .status           (status),
    .granted_index    (granted_index),
    .count_after      (count_after),
    .returned_to_pool (returned_to_pool),
    .free_entries     (free_entries)
  );

endmodule

`default_nettype wire

FILE: rtl/bp_chk.sv
// port-level checks of the buffer pool and their bind to the top level
// depends on bp_pkg and refcounted_buffer_pool
`default_nettype none

module bp_chk (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       rsp_valid,
  input wire logic                       rsp_stall,
  input wire logic [bp_pkg::STATUS_W-1:0] status,
  input wire logic [bp_pkg::IDX_W-1:0]   granted_index,
  input wire logic [bp_pkg::COUNT_W-1:0] count_after,
  input wire logic                       returned_to_pool,
  input wire logic [bp_pkg::FREE_W-1:0]  free_entries
);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status <= bp_pkg::ST_REF_ERROR))
    else $error("bad status code");

  a_exhausted_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == bp_pkg::ST_EXHAUSTED) |->
      (free_entries == '0 && granted_index == '0 && count_after == '0))
    else $error("exhausted with free entries left");

  a_return_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && returned_to_pool) |->
      (status == bp_pkg::ST_OK && count_after == '0 && free_entries != '0))
    else $error("return to pool inconsistent");

  a_bad_index: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == bp_pkg::ST_BAD_INDEX) |->
      (count_after == '0 && !returned_to_pool))
    else $error("bad index changed state");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(status) && $stable(granted_index) &&
       $stable(count_after) && $stable(returned_to_pool) && $stable(free_entries)))
    else $error("stalled response beat changed");

endmodule

bind refcounted_buffer_pool bp_chk u_bp_chk (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp_valid),
  .rsp_stall        (rsp_stall),
  .status           (status),
  .granted_index    (granted_index),
  .count_after      (count_after),
  .returned_to_pool (returned_to_pool),
  .free_entries     (free_entries)
);

`default_nettype wire

FILE: dv/refcounted_buffer_pool_checker.sv
`timescale 1ns / 1ps
// checker for refcounted_buffer_pool: keeps its own free ring and count table,
// predicts each response beat from the request beats and compares it field by field
// depends on bp_pkg
module refcounted_buffer_pool_checker
  import bp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  input  wire logic                req_stall,
  input  wire logic [OP_W-1:0]     operation,
  input  wire logic [IDX_W-1:0]    buffer_index,
  input  wire logic                rsp_valid,
  input  wire logic                rsp_stall,
  input  wire logic [STATUS_W-1:0] status,
  input  wire logic [IDX_W-1:0]    granted_index,
  input  wire logic [COUNT_W-1:0]  count_after,
  input  wire logic                returned_to_pool,
  input  wire logic [FREE_W-1:0]   free_entries,
  output int                       errors,
  output int                       pending
);

  typedef struct {
    status_t            status;
    logic [IDX_W-1:0]   granted;
    logic [COUNT_W-1:0] count;
    logic               returned;
    logic [FREE_W-1:0]  free;
  } pool_result_t;

  logic [IDX_W-1:0]   ring_slot [BP_ENTRIES];
  logic [COUNT_W-1:0] ref_count [BP_ENTRIES];
  logic [FREE_W-1:0]  rd_ptr;
  logic [FREE_W-1:0]  wr_ptr;
  pool_result_t       awaited_results [$];
  int                 mismatches = 0;

  function automatic pool_result_t predict_pool_op(logic [OP_W-1:0] op,
                                                   logic [IDX_W-1:0] idx);
    pool_result_t r;
    r.status   = ST_OK;
    r.granted  = idx;
    r.count    = '0;
    r.returned = 1'b0;
    if (op == OP_ALLOC) begin
      if (wr_ptr == rd_ptr) begin
        r.status  = ST_EXHAUSTED;
        r.granted = '0;
      end else begin
        r.granted = ring_slot[rd_ptr % BP_ENTRIES];
        rd_ptr = rd_ptr + 1'b1;
        ref_count[r.granted] = 1;
        r.count = 1;
      end
    end else if (int'(idx) >= BP_ENTRIES) begin
      r.status = ST_BAD_INDEX;
    end else if (op == OP_ADDREF) begin
      r.count = ref_count[idx];
      if (r.count == 0 || int'(r.count) >= (1 << BP_REF_BITS) - 1) begin
        r.status = ST_REF_ERROR;
      end else begin
        r.count = r.count + 1'b1;
        ref_count[idx] = r.count;
      end
    end else begin
      // release, and the unused code that decodes as release
      r.count = ref_count[idx];
      if (r.count == 0) begin
        r.status = ST_DOUBLE_FREE;
      end else begin
        r.count = r.count - 1'b1;
        ref_count[idx] = r.count;
        if (r.count == 0) begin
          ring_slot[wr_ptr % BP_ENTRIES] = idx;
          wr_ptr = wr_ptr + 1'b1;
          r.returned = 1'b1;
        end
      end
    end
    r.free = wr_ptr - rd_ptr;
    return r;
  endfunction

  always @(posedge clk) begin
    pool_result_t want;
    if (rst) begin
      for (int i = 0; i < BP_ENTRIES; i++) begin
        ring_slot[i] = IDX_W'(i);
        ref_count[i] = '0;
      end
      rd_ptr = '0;
      wr_ptr = FREE_W'(BP_ENTRIES);
      awaited_results.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $error("response beat with no request waiting");
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status) begin
            mismatches++;
            $error("status: expected %0d, got %0d", want.status, status);
          end
          if (granted_index !== want.granted) begin
            mismatches++;
            $error("granted_index: expected %0d, got %0d", want.granted, granted_index);
          end
          if (count_after !== want.count) begin
            mismatches++;
            $error("count_after: expected %0d, got %0d", want.count, count_after);
          end
          if (returned_to_pool !== want.returned) begin
            mismatches++;
            $error("returned_to_pool: expected %0d, got %0d", want.returned,
                   returned_to_pool);
          end
          if (free_entries !== want.free) begin
            mismatches++;
            $error("free_entries: expected %0d, got %0d", want.free, free_entries);
          end
        end
      end
      if (req_valid && !req_stall) begin
        awaited_results.push_back(predict_pool_op(operation, buffer_index));
      end
    end
    errors  <= mismatches;
    pending <= awaited_results.size();
  end

endmodule

FILE: dv/refcounted_buffer_pool_test.sv
`timescale 1ns / 1ps
// top of the buffer pool testbench: clock, reset, request and response drivers
// with random idling; depends on bp_pkg, refcounted_buffer_pool and its checker
module refcounted_buffer_pool_test;
  import bp_pkg::*;

  localparam logic [OP_W-1:0] OP_RELEASE_HI = 2'd3;
  localparam int HOLD_CYCLES = 200;

  logic                clk = 1'b0;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  logic [OP_W-1:0]     operation;
  logic [IDX_W-1:0]    buffer_index;
  logic                rsp_valid;
  logic                rsp_stall;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    granted_index;
  logic [COUNT_W-1:0]  count_after;
  logic                returned_to_pool;
  logic [FREE_W-1:0]   free_entries;

  int                  error_count;
  int                  awaited_count;
  bit                  idle_on = 1'b1;
  bit                  hold_rsp = 1'b0;
  logic [OP_W-1:0]     ops_in_flight [$];
  logic [IDX_W-1:0]    held_refs [$];

  refcounted_buffer_pool dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .buffer_index(buffer_index),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .granted_index(granted_index), .count_after(count_after),
    .returned_to_pool(returned_to_pool), .free_entries(free_entries)
  );

  refcounted_buffer_pool_checker pool_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .buffer_index(buffer_index),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .granted_index(granted_index), .count_after(count_after),
    .returned_to_pool(returned_to_pool), .free_entries(free_entries),
    .errors(error_count), .pending(awaited_count)
  );

  always #4 clk = ~clk;

  task automatic send_beat(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
    if (idle_on) begin
      while ($urandom_range(99) < 36) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid    <= 1'b1;
    operation    <= op;
    buffer_index <= idx;
    do @(posedge clk); while (req_stall);
    ops_in_flight.push_back(op);
  endtask

  task automatic release_held_ref();
    int k;
    logic [IDX_W-1:0] idx;
    k = $urandom_range(held_refs.size() - 1);
    idx = held_refs[k];
    held_refs.delete(k);
    send_beat(($urandom_range(9) == 0) ? OP_RELEASE_HI : OP_RELEASE, idx);
  endtask

  // track references the pool has granted so that most beats are well formed
  always @(posedge clk) begin
    logic [OP_W-1:0] op;
    if (!rst && rsp_valid && !rsp_stall && ops_in_flight.size() != 0) begin
      op = ops_in_flight.pop_front();
      if (status == ST_OK && (op == OP_ALLOC || op == OP_ADDREF)) begin
        held_refs.push_back(granted_index);
      end
    end
  end

  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        repeat (HOLD_CYCLES) begin
          rsp_stall <= 1'b1;
          @(posedge clk);
        end
        hold_rsp = 1'b0;
      end
      rsp_stall <= idle_on && ($urandom_range(99) < 36);
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int r;
    logic [IDX_W-1:0] target;
    rst          <= 1'b1;
    req_valid    <= 1'b0;
    operation    <= OP_ALLOC;
    buffer_index <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: lifecycle of one entry, misuse of free entries, index extremes
    send_beat(OP_ALLOC, 8'd255);
    send_beat(OP_ADDREF, 8'd0);
    send_beat(OP_RELEASE_HI, 8'd0);
    send_beat(OP_RELEASE, 8'd0);
    send_beat(OP_RELEASE, 8'd0);
    send_beat(OP_ADDREF, 8'd0);
    send_beat(OP_ADDREF, 8'd255);
    send_beat(OP_RELEASE, 8'd255);
    send_beat(OP_RELEASE_HI, 8'd255);
    send_beat(OP_ALLOC, 8'd0);
    send_beat(OP_ALLOC, 8'haa);
    send_beat(OP_ADDREF, 8'd1);
    send_beat(OP_ADDREF, 8'd2);
    send_beat(OP_RELEASE, 8'd1);
    send_beat(OP_RELEASE, 8'd1);
    send_beat(OP_RELEASE, 8'd2);
    send_beat(OP_RELEASE, 8'd2);
    send_beat(OP_ADDREF, 8'h55);

    // pump a fresh entry to the count limit while the receiver holds off
    send_beat(OP_ALLOC, '0);
    req_valid <= 1'b0;
    while (ops_in_flight.size() != 0) @(posedge clk);
    target = held_refs[held_refs.size() - 1];
    hold_rsp = 1'b1;
    repeat (256) send_beat(OP_ADDREF, target);

    // random traffic, mostly on granted references
    repeat (50) begin
      r = $urandom_range(99);
      if (r < 30) begin
        send_beat(OP_ALLOC, IDX_W'($urandom_range(255)));
      end else if (r < 55 && held_refs.size() != 0) begin
        send_beat(OP_ADDREF, held_refs[$urandom_range(held_refs.size() - 1)]);
      end else if (r < 85 && held_refs.size() != 0) begin
        release_held_ref();
      end else begin
        send_beat(OP_W'($urandom_range(3)), IDX_W'($urandom_range(255)));
      end
    end

    // run the pool dry back to back
    idle_on = 1'b0;
    repeat (258) send_beat(OP_ALLOC, IDX_W'($urandom_range(255)));
    idle_on = 1'b1;
    req_valid <= 1'b0;

    @(negedge clk);
    while (awaited_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bp_pkg.sv
rtl/bp_ram.sv
rtl/bp_front.sv
rtl/bp_back.sv
rtl/refcounted_buffer_pool.sv
rtl/bp_chk.sv
dv/refcounted_buffer_pool_checker.sv
dv/refcounted_buffer_pool_test.sv
